[hdl/joystick_tank_drive_mixer_unit_defines.svh]
// assertion macros for the joystick tank drive mixer
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef JOYSTICK_TANK_DRIVE_MIXER_UNIT_DEFINES_SVH
`define JOYSTICK_TANK_DRIVE_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define JTDM_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("jtdm: %m failed");
`define JTDM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("jtdm: %m failed");
`else
`define JTDM_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define JTDM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

[hdl/jtdm_pkg.sv]
// shared types, constants and helpers of the joystick tank drive mixer
// no dependencies; imported by the divider, frame and top modules
`default_nettype none

package jtdm_pkg;

  localparam int TIME_BITS_DEF = 32;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_HOLD  = 2'd0,
    CFG_PWM_TOP   = 2'd1,
    CFG_PULSE_MIN = 2'd2,
    CFG_PULSE_MAX = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] ARM_HOLD_RST  = 16'd2000;
  localparam logic [CFG_W-1:0] PWM_TOP_RST   = 16'd39999;
  localparam logic [CFG_W-1:0] PULSE_MIN_RST = 16'd1800;
  localparam logic [CFG_W-1:0] PULSE_MAX_RST = 16'd4000;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [7:0] DEC_KEY   = 8'h17;
  localparam logic [7:0] FRAME_SOF = 8'hFA;
  localparam logic [7:0] ARM_OFF   = 8'hFB;
  localparam logic [7:0] ARM_ON    = 8'hFC;
  localparam logic [7:0] FRAME_PAD = 8'h00;

  // calibration phases: even waits for a z press, odd for its release
  localparam int PHASE_W = 4;
  localparam logic [PHASE_W-1:0] PH_MIN_Y    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_MAX_Y    = 4'd2;
  localparam logic [PHASE_W-1:0] PH_MIN_X    = 4'd4;
  localparam logic [PHASE_W-1:0] PH_LAST_REL = 4'd7;
  localparam logic [PHASE_W-1:0] PH_DONE     = 4'd8;

  localparam logic [7:0]        X_SPAN    = 8'd200;
  localparam logic [7:0]        Y_SPAN    = 8'd100;
  localparam logic [7:0]        PCT_FULL  = 8'd100;
  localparam logic signed [7:0] X_OUT_MIN = -8'sd100;
  localparam logic signed [7:0] X_OUT_MAX = 8'sd100;
  localparam logic [6:0]        Y_OUT_MIN = 7'd0;
  localparam logic [6:0]        Y_OUT_MAX = 7'd100;

  // shared multiplier and divider
  localparam int MUL_A_W       = 18;
  localparam int DIV_W         = 24;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_STEPS     = DIV_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [6:0]  left;
    logic [6:0]  right;
    logic        toggle;
    logic [7:0]  code;
    logic [15:0] lc;
    logic [15:0] rc;
  } frame_req_t;

  function automatic logic [7:0] decode_byte(input logic [7:0] b);
    return (b ^ DEC_KEY) + DEC_KEY;
  endfunction

endpackage

`default_nettype wire

[hdl/jtdm_in_if.sv]
// input channel of the mixer: tick or controller sample words
// no dependencies
`default_nettype none

interface jtdm_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] raw_joy_x;
  logic [7:0] raw_joy_y;
  logic [7:0] raw_buttons;

  modport source (output valid, output command, output raw_joy_x, output raw_joy_y,
                  output raw_buttons, input ready);
  modport sink (input valid, input command, input raw_joy_x, input raw_joy_y,
                input raw_buttons, output ready);
endinterface

`default_nettype wire

[hdl/jtdm_out_if.sv]
// result channel of the mixer: frame bytes with servo compare values
// no dependencies
`default_nettype none

interface jtdm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] left_compare;
  logic [15:0] right_compare;

  modport source (output valid, output tx_byte, output last, output left_compare,
                  output right_compare, input ready);
  modport sink (input valid, input tx_byte, input last, input left_compare,
                input right_compare, output ready);
endinterface

`default_nettype wire

[hdl/jtdm_div.sv]
// shared iterative signed divider, two quotient bits per cycle
// depends on jtdm_pkg; quotient truncates toward zero
`default_nettype none

module jtdm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [jtdm_pkg::DIV_W-1:0]  dividend,
  input  logic [7:0]                         divisor,
  output logic                               done,
  output logic signed [jtdm_pkg::DIV_W-1:0]  quotient
);
  import jtdm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [7:0]           rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic                 neg_r;
  logic [7:0]           dvs_r;
  logic [DIV_W-1:0]     mag;

  assign mag = dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;

  // restoring steps; dividend bits shift out the top while quotient bits enter
  always_comb begin
    logic [8:0] t;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      t = {rem_nxt, quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        t = t - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = t[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag;
      neg_r <= dividend[DIV_W-1];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = $signed(neg_r ? (~quo_r + 1'b1) : quo_r);

endmodule

`default_nettype wire

[hdl/jtdm_frame.sv]
// frame register and byte sequencer for the serial output words
// depends on jtdm_pkg and jtdm_out_if
`default_nettype none

module jtdm_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  jtdm_pkg::frame_req_t req,
  output logic                 free,
  jtdm_out_if.source           out_ch
);
  import jtdm_pkg::*;

  localparam logic [2:0] BYTE_SOF     = 3'd0;
  localparam logic [2:0] BYTE_LEFT    = 3'd1;
  localparam logic [2:0] BYTE_RIGHT   = 3'd2;
  localparam logic [2:0] BYTE_CHECK   = 3'd3;
  localparam logic [2:0] BYTE_ARM_SOF = 3'd4;
  localparam logic [2:0] BYTE_ARM_A   = 3'd5;
  localparam logic [2:0] BYTE_ARM_B   = 3'd6;
  localparam logic [2:0] BYTE_END     = 3'd7;

  logic       valid_r;
  logic [2:0] idx_r;
  frame_req_t req_r;
  logic [7:0] tx;
  logic       is_last;

  always_comb begin
    case (idx_r)
      BYTE_SOF:     tx = FRAME_SOF;
      BYTE_LEFT:    tx = {1'b0, req_r.left};
      BYTE_RIGHT:   tx = {1'b0, req_r.right};
      BYTE_CHECK:   tx = {1'b0, req_r.left ^ req_r.right};
      BYTE_ARM_SOF: tx = FRAME_SOF;
      BYTE_ARM_A:   tx = req_r.code;
      BYTE_ARM_B:   tx = req_r.code;
      BYTE_END:     tx = FRAME_PAD;
      default:      tx = FRAME_PAD;
    endcase
  end

  // arming frame follows the mix frame only on a toggle
  assign is_last = ((idx_r == BYTE_CHECK) && !req_r.toggle) || (idx_r == BYTE_END);

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= req;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= BYTE_SOF;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= BYTE_SOF;
    end else if (valid_r && out_ch.ready) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assign free                 = !valid_r;
  assign out_ch.valid         = valid_r;
  assign out_ch.tx_byte       = tx;
  assign out_ch.last          = is_last;
  assign out_ch.left_compare  = req_r.lc;
  assign out_ch.right_compare = req_r.rc;

endmodule

`default_nettype wire

[hdl/joystick_tank_drive_mixer_unit.sv]
// joystick tank drive mixer: a tick or calibration word is taken while idle.
// a drive sample keeps ready low through four divider passes (load, 12 two-bit
// steps, done) plus mix and send; a zero or inverted x or y span skips that pass's
// divider wait. the send state also waits while the frame register still holds
// earlier words, which leave one per cycle while the output is ready.
// reset (synchronous, active low) restores register defaults and clears calibration.
`default_nettype none
`include "joystick_tank_drive_mixer_unit_defines.svh"

module joystick_tank_drive_mixer_unit #(
  parameter int TIME_BITS = jtdm_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [jtdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jtdm_pkg::CFG_W-1:0]     cfg_data,
  jtdm_in_if.sink                        in_ch,
  jtdm_out_if.source                     out_ch
);
  import jtdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XLOAD, S_XWAIT, S_YLOAD, S_YWAIT, S_MIX,
    S_LLOAD, S_LWAIT, S_RLOAD, S_RWAIT, S_SEND
  } state_t;

  logic [CFG_W-1:0] arm_hold_r, pwm_top_r, pulse_min_r, pulse_max_r;

  state_t               state_r, state_nxt;
  logic [PHASE_W-1:0]   cal_phase_r, cal_phase_nxt;
  logic [7:0]           min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic [7:0]           min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic [TIME_BITS-1:0] ms_count_r, ms_count_nxt, press_start_r, press_start_nxt;
  logic                 armed_r, armed_nxt;
  logic                 toggle_r, toggle_nxt;
  logic [7:0]           x_r, x_nxt, y_r, y_nxt;
  logic                 cpress_r, cpress_nxt;
  logic signed [7:0]    jx_r, jx_nxt;
  logic [6:0]           jy_r, jy_nxt;
  logic [6:0]           left_r, left_nxt, right_r, right_nxt;
  logic [15:0]          lc_r, lc_nxt, rc_r, rc_nxt;

  logic                 in_acc;
  logic                 tick_acc;
  logic                 div_wait;
  logic [7:0]           dec_x, dec_y, dec_btn;
  logic                 z_press;
  logic                 hold_over;

  logic [7:0]           map_v, map_lo, map_hi, map_c, map_off, map_span;
  logic                 span_zero, span_inv;

  logic signed [MUL_A_W-1:0] pulse_diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [7:0]                mul_b;
  logic signed [MUL_A_W+8:0] mul_p;
  logic [7:0]                div_divisor;
  logic                      div_start, div_done;
  logic signed [DIV_W-1:0]   div_q;

  logic signed [8:0]    mix_l, mix_r;
  logic                 frm_load, frm_free;
  frame_req_t           frm_req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_hold_r  <= ARM_HOLD_RST;
      pwm_top_r   <= PWM_TOP_RST;
      pulse_min_r <= PULSE_MIN_RST;
      pulse_max_r <= PULSE_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ARM_HOLD:  arm_hold_r  <= cfg_data;
        CFG_PWM_TOP:   pwm_top_r   <= cfg_data;
        CFG_PULSE_MIN: pulse_min_r <= cfg_data;
        CFG_PULSE_MAX: pulse_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign tick_acc = in_acc && (in_ch.command == CMD_TICK);
  assign div_wait = (state_r == S_XWAIT) || (state_r == S_YWAIT) || (state_r == S_LWAIT) ||
                    (state_r == S_RWAIT);
  assign dec_x    = decode_byte(in_ch.raw_joy_x);
  assign dec_y    = decode_byte(in_ch.raw_joy_y);
  assign dec_btn  = decode_byte(in_ch.raw_buttons);
  assign z_press  = !dec_btn[0];

  assign hold_over = (ms_count_r - press_start_r) > TIME_BITS'(arm_hold_r);

  // range mapping operands, x in S_XLOAD and y otherwise
  assign map_v     = (state_r == S_XLOAD) ? x_r : y_r;
  assign map_lo    = (state_r == S_XLOAD) ? min_x_r : min_y_r;
  assign map_hi    = (state_r == S_XLOAD) ? max_x_r : max_y_r;
  assign map_c     = (map_v < map_lo) ? map_lo : ((map_v > map_hi) ? map_hi : map_v);
  assign map_off   = map_c - map_lo;
  assign map_span  = map_hi - map_lo;
  assign span_zero = (map_lo == map_hi);
  assign span_inv  = (map_lo > map_hi);

  assign pulse_diff = $signed({2'b00, pulse_max_r}) - $signed({2'b00, pulse_min_r});

  // shared multiplier feeding the divider
  always_comb begin
    mul_a       = $signed(MUL_A_W'(map_off));
    mul_b       = (state_r == S_XLOAD) ? X_SPAN : Y_SPAN;
    div_divisor = map_span;
    if (state_r == S_LLOAD || state_r == S_RLOAD) begin
      mul_a       = pulse_diff;
      mul_b       = {1'b0, (state_r == S_LLOAD) ? left_r : right_r};
      div_divisor = PCT_FULL;
    end
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  jtdm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ($signed(mul_p[DIV_W-1:0])),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mix_l = $signed({jx_r[7], jx_r}) + $signed({2'b00, jy_r});
  assign mix_r = $signed({2'b00, jy_r}) - $signed({jx_r[7], jx_r});

  function automatic logic [6:0] clamp_pct(input logic signed [8:0] v);
    if (v < 0) begin
      return 7'd0;
    end else if (v > $signed({1'b0, PCT_FULL})) begin
      return PCT_FULL[6:0];
    end
    return v[6:0];
  endfunction

  always_comb begin
    state_nxt       = state_r;
    cal_phase_nxt   = cal_phase_r;
    min_x_nxt       = min_x_r;
    max_x_nxt       = max_x_r;
    min_y_nxt       = min_y_r;
    max_y_nxt       = max_y_r;
    ms_count_nxt    = ms_count_r;
    press_start_nxt = press_start_r;
    armed_nxt       = armed_r;
    toggle_nxt      = toggle_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    cpress_nxt      = cpress_r;
    jx_nxt          = jx_r;
    jy_nxt          = jy_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    lc_nxt          = lc_r;
    rc_nxt          = rc_r;
    div_start       = 1'b0;
    frm_load        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.command == CMD_TICK) begin
            ms_count_nxt = ms_count_r + 1'b1;
          end else begin
            x_nxt      = dec_x;
            y_nxt      = dec_y;
            cpress_nxt = !dec_btn[1];
            if (cal_phase_r == PH_DONE) begin
              state_nxt = S_XLOAD;
            end else if (!cal_phase_r[0]) begin
              if (z_press) begin
                case (cal_phase_r)
                  PH_MIN_Y: min_y_nxt = dec_y;
                  PH_MAX_Y: max_y_nxt = dec_y;
                  PH_MIN_X: min_x_nxt = dec_x;
                  default:  max_x_nxt = dec_x;
                endcase
                cal_phase_nxt = cal_phase_r + 1'b1;
              end
            end else if (!z_press) begin
              cal_phase_nxt = cal_phase_r + 1'b1;
              // the release closing calibration is also a drive sample
              if (cal_phase_r == PH_LAST_REL) begin
                state_nxt = S_XLOAD;
              end
            end
          end
        end
      end
      S_XLOAD: begin
        if (span_zero) begin
          jx_nxt    = X_OUT_MIN;
          state_nxt = S_YLOAD;
        end else if (span_inv) begin
          jx_nxt    = (map_c == map_lo) ? X_OUT_MIN : X_OUT_MAX;
          state_nxt = S_YLOAD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_XWAIT;
        end
      end
      S_XWAIT: begin
        if (div_done) begin
          jx_nxt    = $signed(div_q[7:0]) + X_OUT_MIN;
          state_nxt = S_YLOAD;
        end
      end
      S_YLOAD: begin
        if (span_zero) begin
          jy_nxt    = Y_OUT_MIN;
          state_nxt = S_MIX;
        end else if (span_inv) begin
          jy_nxt    = (map_c == map_lo) ? Y_OUT_MIN : Y_OUT_MAX;
          state_nxt = S_MIX;
        end else begin
          div_start = 1'b1;
          state_nxt = S_YWAIT;
        end
      end
      S_YWAIT: begin
        if (div_done) begin
          jy_nxt    = div_q[6:0];
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        left_nxt   = clamp_pct(mix_l);
        right_nxt  = clamp_pct(mix_r);
        toggle_nxt = 1'b0;
        if (!cpress_r || hold_over) begin
          press_start_nxt = ms_count_r;
        end
        if (cpress_r && hold_over) begin
          toggle_nxt = 1'b1;
        end
        state_nxt = S_LLOAD;
      end
      S_LLOAD: begin
        div_start = 1'b1;
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (div_done) begin
          lc_nxt    = pwm_top_r - pulse_min_r - div_q[15:0];
          state_nxt = S_RLOAD;
        end
      end
      S_RLOAD: begin
        div_start = 1'b1;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        if (div_done) begin
          rc_nxt    = pwm_top_r - pulse_min_r - div_q[15:0];
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (frm_free) begin
          frm_load = 1'b1;
          if (toggle_r) begin
            armed_nxt = !armed_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    toggle_r <= toggle_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cpress_r <= cpress_nxt;
    jx_r     <= jx_nxt;
    jy_r     <= jy_nxt;
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    lc_r     <= lc_nxt;
    rc_r     <= rc_nxt;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cal_phase_r   <= PH_MIN_Y;
      min_x_r       <= '0;
      max_x_r       <= '0;
      min_y_r       <= '0;
      max_y_r       <= '0;
      ms_count_r    <= '0;
      press_start_r <= '0;
      armed_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cal_phase_r   <= cal_phase_nxt;
      min_x_r       <= min_x_nxt;
      max_x_r       <= max_x_nxt;
      min_y_r       <= min_y_nxt;
      max_y_r       <= max_y_nxt;
      ms_count_r    <= ms_count_nxt;
      press_start_r <= press_start_nxt;
      armed_r       <= armed_nxt;
    end
  end

  always_comb begin
    frm_req.left   = left_r;
    frm_req.right  = right_r;
    frm_req.toggle = toggle_r;
    frm_req.code   = armed_r ? ARM_OFF : ARM_ON;
    frm_req.lc     = lc_r;
    frm_req.rc     = rc_r;
  end

  jtdm_frame u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (frm_load),
    .req    (frm_req),
    .free   (frm_free),
    .out_ch (out_ch)
  );

  `JTDM_ASSERT_IMPL(a_cal_bound, clk, rst_n, 1'b1, cal_phase_r <= PH_DONE)
  `JTDM_ASSERT_NEXT(a_tick_count, clk, rst_n, tick_acc, ms_count_r == $past(ms_count_r) + 1'b1)
  `JTDM_ASSERT_NEXT(a_armed_hold, clk, rst_n, !frm_load, $stable(armed_r))
  `JTDM_ASSERT_IMPL(a_div_in_wait, clk, rst_n, div_done, div_wait)

endmodule

`default_nettype wire
